// ===== src/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlc_pkg: shared types and constants of the keyed cache with expiry.
// Holds the payload structs, operation and register codes, and the
// command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [0:0] REG_TTL = 1'b0;
    localparam logic [0:0] REG_MAX = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key;
        logic [31:0] response_handle;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] found_handle;
        logic [6:0]  entry_count;
        logic [6:0]  removed_count;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND,
        ST_LOOKUP_DONE,
        ST_PLACE,
        ST_PURGE_RD,
        ST_PURGE,
        ST_EVICT_RD,
        ST_EVICT,
        ST_EVICT_DROP,
        ST_STAGE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             load_req;
        logic             clear_all;
        logic             clear_scan;
        logic             step_scan;
        logic             find_step;
        logic             purge_step;
        logic             vic_init;
        logic             evict_step;
        logic             lookup_apply;
        logic             place;
        logic             evict_drop;
        logic             stage_move;
        logic             emit;
    } cmd_t;

    typedef struct packed {
        logic             scan_last;
        logic             over_limit;
    } sts_t;

endpackage

// ===== src/ttl_lru_key_cache.sv =====
// ----------------------------------------------------------------------------
// ttl_lru_key_cache: keyed response cache with age expiry and LRU eviction.
// Top level: configuration registers, sequencer and entry datapath.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on rsp for one cycle with rsp_valid, and must be captured then.
// A lookup makes one pass over the entry store, one store read per cycle,
// for the key search; a clear makes none. An insert makes the search and
// expiry passes plus one victim pass for each eviction, all over the
// single-read entry store.
module ttl_lru_key_cache import tlc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    output logic        rsp_valid,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] ttl_reg;
    logic [6:0]  max_reg;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg <= 32'd3600;
            max_reg <= 7'd64;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TTL: ttl_reg <= cfg_data;
                REG_MAX: max_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    tlc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (req.op),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    tlc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .ttl_limit  (ttl_reg),
        .keep_limit (max_reg),
        .cmd        (cmd),
        .sts        (sts),
        .rsp        (rsp),
        .rsp_valid  (rsp_valid)
    );

endmodule

// ===== src/tlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlc_ctrl: sequencer of the cache.
// Walks the entry store one address per cycle for key search, expiry purge
// and victim search, runs the staging move, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module tlc_ctrl import tlc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] op,
    input  sts_t       sts,
    output cmd_t       cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;
    logic [1:0] op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_LOOKUP;
        end
        else
        begin
            state_reg <= state_next;
            if (start && state_reg == ST_IDLE)
            begin
                op_reg <= op;
            end
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    cmd.clear_scan = 1'b1;
                    case (op)
                        OP_LOOKUP, OP_INSERT: state_next = ST_FIND_RD;
                        OP_CLEAR:
                        begin
                            cmd.clear_all = 1'b1;
                            state_next = ST_DONE;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_FIND_RD:
            begin
                cmd.step_scan = 1'b1;
                state_next = ST_FIND;
            end
            ST_FIND:
            begin
                cmd.find_step = 1'b1;
                cmd.step_scan = 1'b1;
                if (sts.scan_last)
                begin
                    cmd.clear_scan = 1'b1;
                    state_next = (op_reg == OP_LOOKUP) ? ST_LOOKUP_DONE : ST_PLACE;
                end
            end
            ST_LOOKUP_DONE:
            begin
                cmd.lookup_apply = 1'b1;
                state_next = ST_DONE;
            end
            ST_PLACE:
            begin
                cmd.place = 1'b1;
                state_next = ST_PURGE_RD;
            end
            ST_PURGE_RD:
            begin
                cmd.step_scan = 1'b1;
                state_next = ST_PURGE;
            end
            ST_PURGE:
            begin
                cmd.purge_step = 1'b1;
                cmd.step_scan = 1'b1;
                if (sts.scan_last)
                begin
                    cmd.clear_scan = 1'b1;
                    state_next = ST_EVICT_RD;
                end
            end
            ST_EVICT_RD:
            begin
                if (!sts.over_limit)
                begin
                    state_next = ST_STAGE;
                end
                else
                begin
                    cmd.vic_init = 1'b1;
                    cmd.step_scan = 1'b1;
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                cmd.evict_step = 1'b1;
                cmd.step_scan = 1'b1;
                if (sts.scan_last)
                begin
                    cmd.clear_scan = 1'b1;
                    state_next = ST_EVICT_DROP;
                end
            end
            ST_EVICT_DROP:
            begin
                cmd.evict_drop = 1'b1;
                state_next = ST_EVICT_RD;
            end
            ST_STAGE:
            begin
                cmd.stage_move = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.emit = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> !busy)
        else $error("result strobe must end the operation");
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted start must raise busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.find_step, cmd.purge_step, cmd.evict_step}))
        else $error("only one scan kind may run at a time");
`endif

endmodule

// ===== src/tlc_dp.sv =====
// ----------------------------------------------------------------------------
// tlc_dp: entry store and scan datapath of the cache.
// Keeps the entry memories, valid bits and count, and runs the per-entry
// compare for search, expiry and victim selection.
// ----------------------------------------------------------------------------
module tlc_dp import tlc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        req,
    input  logic [31:0] ttl_limit,
    input  logic [6:0]  keep_limit,
    input  cmd_t        cmd,
    output sts_t        sts,
    output rsp_t        rsp,
    output logic        rsp_valid
);

    logic [63:0] key_mem [CAPACITY];
    logic [31:0] hnd_mem [CAPACITY];
    logic [31:0] crt_mem [CAPACITY];
    logic [31:0] use_mem [CAPACITY];
    logic [CAPACITY-1:0] valid_reg;
    logic [CNT_W-1:0] count_reg;

    req_t req_reg;
    logic [IDX_W:0] scan_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [63:0] rd_key;
    logic [31:0] rd_hnd, rd_crt, rd_use;

    logic found_reg;
    logic [IDX_W-1:0] found_idx_reg;
    logic [31:0] fnd_hnd_reg;
    logic [31:0] fnd_crt_reg;
    logic free_ok_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [6:0] removed_reg;

    logic stg_valid_reg;
    logic [63:0] stg_key_reg;
    logic [31:0] stg_hnd_reg, stg_crt_reg, stg_use_reg;

    logic vic_ok_reg;
    logic vic_stg_reg;
    logic [IDX_W-1:0] vic_idx_reg;
    logic [63:0] vic_key_reg;
    logic [31:0] vic_use_reg;

    logic hit_reg;
    logic [31:0] fh_reg;

    logic [CNT_W-1:0] limit;
    logic [IDX_W-1:0] scan_idx;
    logic rd_valid;
    logic rd_expired;
    logic fnd_expired;
    logic [CNT_W:0] live;
    logic better;

    assign scan_idx = scan_reg[IDX_W-1:0];
    assign limit = (keep_limit > 7'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(keep_limit);
    assign rd_valid = valid_reg[rd_idx_reg];
    assign rd_expired = (req_reg.now - rd_crt) > ttl_limit;
    assign fnd_expired = (req_reg.now - fnd_crt_reg) > ttl_limit;
    assign live = {1'b0, count_reg} + (CNT_W+1)'(stg_valid_reg);
    assign better = !vic_ok_reg || (rd_use < vic_use_reg) ||
                    (rd_use == vic_use_reg && rd_key < vic_key_reg);

    assign sts.scan_last = (rd_idx_reg == IDX_W'(CAPACITY - 1)) && scan_reg[IDX_W];
    assign sts.over_limit = live > {1'b0, limit};

    always_ff @(posedge clk)
    begin
        rd_key <= key_mem[scan_idx];
        rd_hnd <= hnd_mem[scan_idx];
        rd_crt <= crt_mem[scan_idx];
        rd_use <= use_mem[scan_idx];
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.lookup_apply && found_reg && !fnd_expired)
        begin
            use_mem[found_idx_reg] <= req_reg.now;
        end
        if (cmd.place && found_reg)
        begin
            key_mem[found_idx_reg] <= req_reg.key;
            hnd_mem[found_idx_reg] <= req_reg.response_handle;
            crt_mem[found_idx_reg] <= req_reg.now;
            use_mem[found_idx_reg] <= req_reg.now;
        end
        else if (cmd.place && free_ok_reg)
        begin
            key_mem[free_idx_reg] <= req_reg.key;
            hnd_mem[free_idx_reg] <= req_reg.response_handle;
            crt_mem[free_idx_reg] <= req_reg.now;
            use_mem[free_idx_reg] <= req_reg.now;
        end
        else if (cmd.stage_move && stg_valid_reg && free_ok_reg)
        begin
            key_mem[free_idx_reg] <= stg_key_reg;
            hnd_mem[free_idx_reg] <= stg_hnd_reg;
            crt_mem[free_idx_reg] <= stg_crt_reg;
            use_mem[free_idx_reg] <= stg_use_reg;
        end
        if (cmd.place && !found_reg && !free_ok_reg)
        begin
            stg_key_reg <= req_reg.key;
            stg_hnd_reg <= req_reg.response_handle;
            stg_crt_reg <= req_reg.now;
            stg_use_reg <= req_reg.now;
        end
        if (cmd.evict_step && rd_valid && better)
        begin
            vic_idx_reg <= rd_idx_reg;
            vic_key_reg <= rd_key;
            vic_use_reg <= rd_use;
        end
        else if (cmd.vic_init)
        begin
            vic_key_reg <= stg_key_reg;
            vic_use_reg <= stg_use_reg;
        end
        if (cmd.find_step && rd_valid && rd_key == req_reg.key)
        begin
            found_idx_reg <= rd_idx_reg;
            fnd_hnd_reg <= rd_hnd;
            fnd_crt_reg <= rd_crt;
        end
        if (cmd.find_step && !rd_valid && !free_ok_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        else if (cmd.evict_drop && !vic_stg_reg)
        begin
            free_idx_reg <= vic_idx_reg;
        end
        else if (cmd.purge_step && rd_valid && rd_expired)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.lookup_apply)
        begin
            fh_reg <= fnd_hnd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            scan_reg <= '0;
            rd_idx_reg <= '0;
            found_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            removed_reg <= '0;
            stg_valid_reg <= 1'b0;
            vic_ok_reg <= 1'b0;
            vic_stg_reg <= 1'b0;
            hit_reg <= 1'b0;
            rsp_valid <= 1'b0;
        end
        else
        begin
            rsp_valid <= cmd.emit;
            rd_idx_reg <= scan_idx;
            if (cmd.clear_scan)
            begin
                scan_reg <= '0;
            end
            else if (cmd.step_scan)
            begin
                scan_reg <= (scan_idx == IDX_W'(CAPACITY - 1)) ?
                    {1'b1, scan_idx} : scan_reg + 1'b1;
            end
            if (cmd.load_req)
            begin
                found_reg <= 1'b0;
                free_ok_reg <= 1'b0;
                removed_reg <= '0;
                hit_reg <= 1'b0;
            end
            if (cmd.clear_all)
            begin
                valid_reg <= '0;
                count_reg <= '0;
                stg_valid_reg <= 1'b0;
            end
            if (cmd.find_step && rd_valid && rd_key == req_reg.key)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.find_step && !rd_valid)
            begin
                free_ok_reg <= 1'b1;
            end
            if (cmd.lookup_apply && found_reg)
            begin
                if (fnd_expired)
                begin
                    valid_reg[found_idx_reg] <= 1'b0;
                    count_reg <= count_reg - 1'b1;
                    removed_reg <= 7'd1;
                end
                else
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.place && !found_reg)
            begin
                if (free_ok_reg)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    stg_valid_reg <= 1'b1;
                end
                free_ok_reg <= 1'b0;
            end
            else if (cmd.place)
            begin
                free_ok_reg <= 1'b0;
            end
            if (cmd.purge_step && rd_valid && rd_expired)
            begin
                valid_reg[rd_idx_reg] <= 1'b0;
                count_reg <= count_reg - 1'b1;
                removed_reg <= removed_reg + 1'b1;
                free_ok_reg <= 1'b1;
            end
            if (cmd.vic_init)
            begin
                vic_ok_reg <= stg_valid_reg;
                vic_stg_reg <= stg_valid_reg;
            end
            if (cmd.evict_step && rd_valid && better)
            begin
                vic_ok_reg <= 1'b1;
                vic_stg_reg <= 1'b0;
            end
            if (cmd.evict_drop)
            begin
                removed_reg <= removed_reg + 1'b1;
                if (vic_stg_reg)
                begin
                    stg_valid_reg <= 1'b0;
                end
                else
                begin
                    valid_reg[vic_idx_reg] <= 1'b0;
                    count_reg <= count_reg - 1'b1;
                    free_ok_reg <= 1'b1;
                end
            end
            if (cmd.stage_move && stg_valid_reg && free_ok_reg)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                count_reg <= count_reg + 1'b1;
                stg_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.hit = hit_reg;
    assign rsp.found_handle = hit_reg ? fh_reg : 32'd0;
    assign rsp.entry_count = 7'(count_reg);
    assign rsp.removed_count = removed_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(count_reg) == 32'($countones(valid_reg))))
        else $error("entry count disagrees with valid bits");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !stg_valid_reg)
        else $error("staging slot still full at result");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.hit |-> rsp.removed_count == 7'd0)
        else $error("hit cannot remove entries");
`endif

endmodule
